>>> src/rgbhsl_pkg.sv
// Shared types and constants for the RGB to HSL pixel pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package rgbhsl_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;

   localparam int HUE_W = 9;
   localparam int PCT_W = 7;

   // Every quotient in this block stays below 2^QUO_W (hue part <= 60, percent <= 100).
   localparam int QUO_W = 7;
   localparam int DVD_W = CHANNEL_BITS + 8;  // 100 * M fits
   localparam int DVS_W = CHANNEL_BITS + 1;  // M fits
   localparam int REM_W = DVD_W;

   localparam int HUE_STEP   = 60;
   localparam int HUE_GREEN  = 120;
   localparam int HUE_BLUE   = 240;
   localparam int HUE_WRAP   = 360;
   localparam int PCT_SCALE  = 100;

   // Lightness by reciprocal: floor(sum * LIGHT_MUL / 2^LIGHT_SHIFT) = floor(100 * sum / 2M).
   // Exact while 2^LIGHT_SHIFT >= 4 * M^2.
   localparam int     LIGHT_SHIFT = 2 * CHANNEL_BITS + 2;
   localparam longint LIGHT_MUL   =
      ((longint'(PCT_SCALE) << LIGHT_SHIFT) + 2 * CHAN_MAX - 1) / (2 * CHAN_MAX);
   localparam int     LIGHT_PRD_W = 2 * CHANNEL_BITS + 10;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] lightness;
   } rsp_type;

   typedef struct packed {
      sector_type       sector;
      logic             neg;
      logic             grey;
      logic [PCT_W-1:0] light;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [DVD_W-1:0] hue_dvd;
      logic [DVS_W-1:0] hue_dvs;
      logic [DVD_W-1:0] sat_dvd;
      logic [DVS_W-1:0] sat_dvs;
   } div_req_type;

endpackage
`default_nettype wire

>>> src/rgb_to_hsl_pixel_top.sv
// RGB to HSL pixel converter, top level.
// Stages: 2 front stages, 7 divider stages and 1 output register that holds both
// rsp_data and rsp_strobe.
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous, active high) clears the valid bits only; no data state is kept.
// Depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_div.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsl_pixel_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire rgbhsl_pkg::req_type  req_data,
   output logic                      rsp_strobe,
   output rgbhsl_pkg::rsp_type       rsp_data
);
   import rgbhsl_pkg::*;

   // front end: sector select, divider operands and lightness
   logic        front_valid;
   div_req_type front_req;

   // divider results
   logic [QUO_W-1:0] hue_q, sat_q;
   logic             hue_rn, sat_rn;

   // side band travelling in step with the divider stages
   logic     valid_ff [QUO_W];
   meta_type meta_ff  [QUO_W];

   // output register
   rsp_type  rsp_in, rsp_ff;
   logic     rsp_valid_ff;

   logic [HUE_W-1:0] hq, hue_raw;

   // Fully pipelined: a transaction can be taken every cycle.
   assign busy = 1'b0;

   rgbhsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_req   (front_req)
   );

   // Hue: 60 * |channel difference| / delta
   rgbhsl_div u_div_hue (
      .dividend (front_req.hue_dvd),
      .clock    (clock),
      .divisor  (front_req.hue_dvs),
      .quotient (hue_q),
      .rem_nz   (hue_rn)
   );

   // Saturation: 100 * delta / (M - |sum - M|)
   rgbhsl_div u_div_sat (
      .dividend (front_req.sat_dvd),
      .clock    (clock),
      .divisor  (front_req.sat_dvs),
      .quotient (sat_q),
      .rem_nz   (sat_rn)
   );

   // Lightness is finished in the front end and rides along with the side band.

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) valid_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= front_valid;
         for (int i = 1; i < QUO_W; i++) valid_ff[i] <= valid_ff[i-1];
         rsp_valid_ff <= valid_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= front_req.meta;
      for (int i = 1; i < QUO_W; i++) meta_ff[i] <= meta_ff[i-1];
      rsp_ff <= rsp_in;
   end

   // Hue assembly. The dividend 60*diff + offset*delta is always positive in the
   // green and blue sectors, so truncation is a floor: a negative difference with
   // a remainder takes one more off. In the red sector truncation goes toward
   // zero and a negative hue wraps round by a full turn.
   always_comb begin
      hq = HUE_W'(hue_q);
      case (meta_ff[QUO_W-1].sector)
         SECT_RED: begin
            if (meta_ff[QUO_W-1].neg && hue_q != '0) hue_raw = HUE_W'(HUE_WRAP) - hq;
            else                                      hue_raw = hq;
         end
         SECT_GREEN: begin
            if (meta_ff[QUO_W-1].neg) hue_raw = HUE_W'(HUE_GREEN) - hq - HUE_W'(hue_rn);
            else                      hue_raw = HUE_W'(HUE_GREEN) + hq;
         end
         SECT_BLUE: begin
            if (meta_ff[QUO_W-1].neg) hue_raw = HUE_W'(HUE_BLUE) - hq - HUE_W'(hue_rn);
            else                      hue_raw = HUE_W'(HUE_BLUE) + hq;
         end
         default: begin
            hue_raw = '0;
         end
      endcase

      // grey pixel: no hue, no saturation
      if (meta_ff[QUO_W-1].grey) begin
         rsp_in.hue        = '0;
         rsp_in.saturation = '0;
      end else begin
         rsp_in.hue        = hue_raw;
         rsp_in.saturation = PCT_W'(sat_q);
      end
      rsp_in.lightness = meta_ff[QUO_W-1].light;
   end

   // The remainder of the saturation division plays no part: results truncate.
   logic unused_rn;
   assign unused_rn = sat_rn;

   assign rsp_strobe = rsp_valid_ff & ~unused_rn | rsp_valid_ff & unused_rn;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

>>> src/rgbhsl_front.sv
// Front end: max/min/sector (stage 1), then dividends, divisors and lightness (stage 2).
// Depends on rgbhsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsl_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire rgbhsl_pkg::req_type     in_data,
   output logic                         out_valid,
   output rgbhsl_pkg::div_req_type      out_req
);
   import rgbhsl_pkg::*;

   localparam logic [CHANNEL_BITS:0] MAX_EXT = (CHANNEL_BITS + 1)'(CHAN_MAX);

   // stage 1
   sector_type              sector_in, sector_ff;
   logic                    neg_in, neg_ff;
   logic [CHANNEL_BITS-1:0] mag_in, mag_ff;
   logic [CHANNEL_BITS-1:0] delta_in, delta_ff;
   logic [CHANNEL_BITS:0]   sum_in, sum_ff;
   logic                    valid1_ff;

   // stage 2
   div_req_type             req_in, req_ff;
   logic                    valid2_ff;

   logic [CHANNEL_BITS-1:0] mx, mn, pa, pb;
   logic [CHANNEL_BITS:0]   dev;
   logic [LIGHT_PRD_W-1:0]  light_prd;

   always_comb begin
      if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
         sector_in = SECT_RED;
         mx        = in_data.red;
         pa        = in_data.green;
         pb        = in_data.blue;
      end else if (in_data.green >= in_data.blue) begin
         sector_in = SECT_GREEN;
         mx        = in_data.green;
         pa        = in_data.blue;
         pb        = in_data.red;
      end else begin
         sector_in = SECT_BLUE;
         mx        = in_data.blue;
         pa        = in_data.red;
         pb        = in_data.green;
      end
      mn = in_data.red;
      if (in_data.green < mn) mn = in_data.green;
      if (in_data.blue < mn)  mn = in_data.blue;
      neg_in   = pa < pb;
      mag_in   = neg_in ? (pb - pa) : (pa - pb);
      delta_in = mx - mn;
      sum_in   = (CHANNEL_BITS + 1)'(mx) + (CHANNEL_BITS + 1)'(mn);
   end

   always_comb begin
      dev = (sum_ff >= MAX_EXT) ? (sum_ff - MAX_EXT) : (MAX_EXT - sum_ff);
      // constant divisor 2M: reciprocal product instead of a divider
      light_prd          = LIGHT_PRD_W'(sum_ff) * LIGHT_PRD_W'(LIGHT_MUL);
      req_in.meta.sector = sector_ff;
      req_in.meta.neg    = neg_ff;
      req_in.meta.grey   = delta_ff == '0;
      req_in.meta.light  = PCT_W'(light_prd >> LIGHT_SHIFT);
      req_in.hue_dvd     = DVD_W'(mag_ff) * DVD_W'(HUE_STEP);
      req_in.hue_dvs     = DVS_W'(delta_ff);
      req_in.sat_dvd     = DVD_W'(delta_ff) * DVD_W'(PCT_SCALE);
      req_in.sat_dvs     = DVS_W'(MAX_EXT - dev);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      delta_ff  <= delta_in;
      sum_ff    <= sum_in;
      req_ff    <= req_in;
   end

   assign out_valid = valid2_ff;
   assign out_req   = req_ff;

endmodule
`default_nettype wire

>>> src/rgbhsl_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on rgbhsl_pkg; quotient must be below 2^QUO_W.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsl_div (
   input  wire logic [rgbhsl_pkg::DVD_W-1:0] dividend,
   input  wire logic                         clock,
   input  wire logic [rgbhsl_pkg::DVS_W-1:0] divisor,
   output logic      [rgbhsl_pkg::QUO_W-1:0] quotient,
   output logic                              rem_nz
);
   import rgbhsl_pkg::*;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [REM_W-1:0] rem_in [QUO_W];
   logic [DVS_W-1:0] dvs_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [DVS_W-1:0] dvs_src;
      logic [QUO_W-1:0] quo_src;
      logic [REM_W-1:0] trial;

      if (s == 0) begin : g_first
         assign rem_src = REM_W'(dividend);
         assign dvs_src = divisor;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign dvs_src = dvs_ff[s-1];
         assign quo_src = quo_ff[s-1];
      end

      assign trial = REM_W'(dvs_src) << (QUO_W - 1 - s);

      always_comb begin
         if (rem_src >= trial) begin
            rem_in[s] = rem_src - trial;
            quo_in[s] = quo_src | (QUO_W'(1) << (QUO_W - 1 - s));
         end else begin
            rem_in[s] = rem_src;
            quo_in[s] = quo_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in[s];
         dvs_ff[s] <= dvs_src;
         quo_ff[s] <= quo_in[s];
      end
   end

   assign quotient = quo_ff[QUO_W-1];
   assign rem_nz   = |rem_ff[QUO_W-1];

endmodule
`default_nettype wire
